/* rtl/core/shared_pool_linked_queues_defines.svh */
// ----------------------------------------------------------------------------
// Shared pool linked queues: assertion macros
// Common forms for the concurrent checks on the queue block.
// ----------------------------------------------------------------------------
`ifndef SHARED_POOL_LINKED_QUEUES_DEFINES_SVH
`define SHARED_POOL_LINKED_QUEUES_DEFINES_SVH

// Check that is switched off while reset is high.
`define SPLQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that is also evaluated while reset is high.
`define SPLQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/splq_pkg.sv */
// ----------------------------------------------------------------------------
// Shared pool linked queues: package
// Constants, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package splq_pkg;

   localparam int NODES_DEFAULT      = 64;
   localparam int NUM_QUEUES_DEFAULT = 4;
   localparam int DATA_WIDTH         = 32;
   localparam int QID_WIDTH          = 2;
   localparam int LEVEL_WIDTH        = 7;

   localparam logic [LEVEL_WIDTH-1:0] LIMIT_RESET = 7'd30;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef struct packed {
      logic capture;     // take the accepted request into the datapath
      logic mem_read;    // read the pool and judge the request
      logic commit;      // write back links and queue pointers
      logic link_fix;    // link the old tail to the new node
      logic init_write;  // one step of the free-list initialisation walk
      logic load_rsp;    // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic req_ok;
      logic need_link;
      logic init_last;
      logic rsp_busy;
   } status_type;

endpackage

/* rtl/core/splq_ctrl.sv */
// ----------------------------------------------------------------------------
// Shared pool linked queues: controller
// Sequences the initialisation walk and the read/write-back of one request.
// ----------------------------------------------------------------------------
module splq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  splq_pkg::status_type status,
   output splq_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_LINK   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.init_write = 1'b1;
            if (status.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = status.req_ok ? S_COMMIT : S_DONE;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = status.need_link ? S_LINK : S_DONE;
         end
         S_LINK: begin
            cmd.link_fix = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // Hold the result until the output register is free.
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

/* rtl/core/splq_datapath.sv */
// ----------------------------------------------------------------------------
// Shared pool linked queues: datapath
// Link and payload memories, free-list head, queue pointers and result beat.
// ----------------------------------------------------------------------------
module splq_datapath #(
   parameter int NODES      = splq_pkg::NODES_DEFAULT,
   parameter int NUM_QUEUES = splq_pkg::NUM_QUEUES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  splq_pkg::cmd_type                     cmd,
   output splq_pkg::status_type                  status,
   input  logic                                  req_type,
   input  logic [splq_pkg::QID_WIDTH-1:0]        req_queue_id,
   input  logic [splq_pkg::DATA_WIDTH-1:0]       req_item_data,
   input  logic                                  csr_valid,
   input  logic [splq_pkg::LEVEL_WIDTH-1:0]      csr_per_queue_limit,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [splq_pkg::DATA_WIDTH-1:0]       rsp_removed_data,
   output logic                                  rsp_error,
   output logic [splq_pkg::LEVEL_WIDTH-1:0]      rsp_queue_level
);

   localparam int AW = $clog2(NODES);
   localparam int PW = $clog2(NODES + 1);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int DW = splq_pkg::DATA_WIDTH;
   localparam int LW = splq_pkg::LEVEL_WIDTH;
   localparam int QIDW = splq_pkg::QID_WIDTH;
   localparam logic [PW-1:0] NULL_PTR = PW'(NODES);

   // Pool memories
   logic [PW-1:0] link_mem    [NODES];
   logic [DW-1:0] payload_mem [NODES];
   logic [PW-1:0] link_rd_ff;
   logic [DW-1:0] payload_rd_ff;

   // Pool and queue state
   logic [PW-1:0] free_head_ff;
   logic [PW-1:0] head_ff  [NUM_QUEUES];
   logic [PW-1:0] tail_ff  [NUM_QUEUES];
   logic [LW-1:0] count_ff [NUM_QUEUES];
   logic [LW-1:0] limit_ff;
   logic [AW-1:0] init_cnt_ff;

   // Request and result holding
   logic            op_ff;
   logic [QIDW-1:0] qid_ff;
   logic [DW-1:0]   data_ff;
   logic [AW-1:0]   fix_addr_ff;
   logic [PW-1:0]   fix_data_ff;
   logic [DW-1:0]   res_data_ff;
   logic            res_err_ff;
   logic [LW-1:0]   res_level_ff;
   logic            rsp_valid_ff;
   logic [DW-1:0]   rsp_data_ff;
   logic            rsp_err_ff;
   logic [LW-1:0]   rsp_level_ff;

   logic [QW-1:0] qidx;
   logic          in_range;
   logic [LW-1:0] cur_cnt;
   logic [PW-1:0] cur_head;
   logic [PW-1:0] cur_tail;
   logic          is_remove;
   logic          ins_ok;
   logic          rem_ok;
   logic          req_ok;
   logic [AW-1:0] head_addr;
   logic [AW-1:0] free_addr;
   logic [AW-1:0] rd_addr;
   logic [LW-1:0] cnt_inc;
   logic [LW-1:0] cnt_dec;
   logic          lk_we;
   logic [AW-1:0] lk_addr;
   logic [PW-1:0] lk_data;

   assign qidx      = QW'(qid_ff);
   assign in_range  = (32'(qid_ff) < 32'(NUM_QUEUES));
   assign cur_cnt   = in_range ? count_ff[qidx] : '0;
   assign cur_head  = in_range ? head_ff[qidx] : NULL_PTR;
   assign cur_tail  = in_range ? tail_ff[qidx] : NULL_PTR;
   assign is_remove = (op_ff == splq_pkg::REQ_REMOVE);

   // Emptiness is judged from the queue's own count and head.
   assign ins_ok = in_range && (free_head_ff < NULL_PTR) && (cur_cnt < limit_ff);
   assign rem_ok = in_range && (cur_cnt != '0) && (cur_head < NULL_PTR);
   assign req_ok = is_remove ? rem_ok : ins_ok;

   assign head_addr = cur_head[AW-1:0];
   assign free_addr = free_head_ff[AW-1:0];
   assign rd_addr   = is_remove ? head_addr : free_addr;
   assign cnt_inc   = cur_cnt + LW'(1);
   assign cnt_dec   = cur_cnt - LW'(1);

   assign status.req_ok    = req_ok;
   assign status.need_link = !is_remove && (cur_cnt != '0) && (cur_tail < NULL_PTR);
   assign status.init_last = (32'(init_cnt_ff) == NODES - 1);
   assign status.rsp_busy  = rsp_valid_ff && rsp_stall;

   // Single write port on the link memory, shared by all writers.
   always_comb begin
      lk_we   = 1'b0;
      lk_addr = '0;
      lk_data = '0;
      if (cmd.init_write) begin
         lk_we   = 1'b1;
         lk_addr = init_cnt_ff;
         lk_data = PW'(init_cnt_ff) + PW'(1);
      end else if (cmd.commit && !is_remove) begin
         lk_we   = 1'b1;
         lk_addr = free_addr;
         lk_data = NULL_PTR;
      end else if (cmd.commit) begin
         lk_we   = 1'b1;
         lk_addr = head_addr;
         lk_data = free_head_ff;
      end else if (cmd.link_fix) begin
         lk_we   = 1'b1;
         lk_addr = fix_addr_ff;
         lk_data = fix_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_addr] <= lk_data;
      end
      if (cmd.mem_read) begin
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read && !is_remove && ins_ok) begin
         payload_mem[free_addr] <= data_ff;
      end
      if (cmd.mem_read) begin
         payload_rd_ff <= payload_mem[head_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         limit_ff     <= splq_pkg::LIMIT_RESET;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= NULL_PTR;
            tail_ff[i]  <= NULL_PTR;
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_per_queue_limit;
         end
         if (cmd.init_write) begin
            init_cnt_ff <= init_cnt_ff + AW'(1);
         end
         if (cmd.commit && !is_remove) begin
            free_head_ff    <= link_rd_ff;
            tail_ff[qidx]   <= free_head_ff;
            count_ff[qidx]  <= cnt_inc;
            if (cur_cnt == '0 || cur_tail >= NULL_PTR) begin
               head_ff[qidx] <= free_head_ff;
            end
         end else if (cmd.commit) begin
            free_head_ff   <= cur_head;
            count_ff[qidx] <= cnt_dec;
            if (link_rd_ff >= NULL_PTR || cnt_dec == '0) begin
               head_ff[qidx] <= NULL_PTR;
               tail_ff[qidx] <= NULL_PTR;
            end else begin
               head_ff[qidx] <= link_rd_ff;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_type;
         qid_ff  <= req_queue_id;
         data_ff <= req_item_data;
      end
      if (cmd.mem_read && !req_ok) begin
         res_data_ff  <= '0;
         res_err_ff   <= 1'b1;
         res_level_ff <= cur_cnt;
      end
      if (cmd.commit) begin
         fix_addr_ff  <= cur_tail[AW-1:0];
         fix_data_ff  <= free_head_ff;
         res_err_ff   <= 1'b0;
         res_data_ff  <= is_remove ? payload_rd_ff : '0;
         res_level_ff <= is_remove ? cnt_dec : cnt_inc;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff  <= res_data_ff;
         rsp_err_ff   <= res_err_ff;
         rsp_level_ff <= res_level_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_removed_data = rsp_data_ff;
   assign rsp_error        = rsp_err_ff;
   assign rsp_queue_level  = rsp_level_ff;

endmodule

/* rtl/core/shared_pool_linked_queues.sv */
// ----------------------------------------------------------------------------
// Shared pool linked queues
// Several FIFO queues built as linked lists over one shared pool of nodes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Beat
// req       in         req_valid/req_stall  req_type, req_queue_id, req_item_data
// rsp       out        rsp_valid/rsp_stall  rsp_removed_data, rsp_error, rsp_queue_level
// csr       in         csr_valid/csr_ready  csr_per_queue_limit
//
// After reset the free list is linked by a walk over all NODES nodes; req_stall is
// high throughout and csr writes are taken as ever.
// A failed request goes from the read to the result; a remove or an insert into
// an empty queue adds the write-back, and an insert behind an existing tail also
// the tail link, set by the single write port of the link memory. A stalled result
// stays in the output register; the next request is taken and waits only then.
// ----------------------------------------------------------------------------
module shared_pool_linked_queues #(
   parameter int NODES      = splq_pkg::NODES_DEFAULT,
   parameter int NUM_QUEUES = splq_pkg::NUM_QUEUES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [splq_pkg::QID_WIDTH-1:0]        req_queue_id,
   input  logic [splq_pkg::DATA_WIDTH-1:0]       req_item_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [splq_pkg::DATA_WIDTH-1:0]       rsp_removed_data,
   output logic                                  rsp_error,
   output logic [splq_pkg::LEVEL_WIDTH-1:0]      rsp_queue_level,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [splq_pkg::LEVEL_WIDTH-1:0]      csr_per_queue_limit
);

   splq_pkg::cmd_type    cmd;
   splq_pkg::status_type status;

   // The limit register can always take a write.
   assign csr_ready = 1'b1;

   splq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   splq_datapath #(
      .NODES      (NODES),
      .NUM_QUEUES (NUM_QUEUES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_type            (req_type),
      .req_queue_id        (req_queue_id),
      .req_item_data       (req_item_data),
      .csr_valid           (csr_valid && csr_ready),
      .csr_per_queue_limit (csr_per_queue_limit),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_removed_data    (rsp_removed_data),
      .rsp_error           (rsp_error),
      .rsp_queue_level     (rsp_queue_level)
   );

endmodule

/* rtl/core/splq_checker.sv */
// ----------------------------------------------------------------------------
// Shared pool linked queues: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "shared_pool_linked_queues_defines.svh"

module splq_checker #(
   parameter int NODES = splq_pkg::NODES_DEFAULT
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [splq_pkg::DATA_WIDTH-1:0]       rsp_removed_data,
   input logic                                  rsp_error,
   input logic [splq_pkg::LEVEL_WIDTH-1:0]      rsp_queue_level
);

   // A stalled result beat must hold.
   `SPLQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_removed_data) && $stable(rsp_error) && $stable(rsp_queue_level), "result beat changed while stalled")

   // A failed request never carries payload.
   `SPLQ_ASSERT(a_err_zero, clock, reset, rsp_valid && rsp_error |-> rsp_removed_data == '0, "failed request returned data")

   // No queue can hold more than the pool.
   `SPLQ_ASSERT(a_level_pool, clock, reset, rsp_valid |-> 32'(rsp_queue_level) <= NODES, "queue level beyond pool size")

   // The initialisation walk keeps requests out and no result is pending.
   `SPLQ_ASSERT_ALWAYS(a_init_stall, clock, reset |=> req_stall && !rsp_valid, "request taken or result shown after reset")

endmodule

bind shared_pool_linked_queues splq_checker #(.NODES(NODES)) u_splq_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the shared pool linked queues
// Request beats are driven from a backlog and every result is checked against
// a linked-list model of the queues, the free list and the limit register.
// The run moves through several limit settings, fills and drains the pool, and
// idles both sides at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LW          = splq_pkg::LEVEL_WIDTH;
   localparam int QW          = splq_pkg::QID_WIDTH;
   localparam int DW          = splq_pkg::DATA_WIDTH;
   localparam int NODE_COUNT  = splq_pkg::NODES_DEFAULT;
   localparam int QUEUE_COUNT = splq_pkg::NUM_QUEUES_DEFAULT;
   localparam int NODE_AW     = $clog2(NODE_COUNT);
   localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic           kind;
      logic [QW-1:0]  qid;
      logic [DW-1:0]  data;
   } request_type;

   typedef struct packed {
      logic [DW-1:0]  removed;
      logic           err;
      logic [LW-1:0]  level;
   } outcome_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   logic           req_type = splq_pkg::REQ_INSERT;
   logic [QW-1:0]  req_queue_id = '0;
   logic [DW-1:0]  req_item_data = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   logic [DW-1:0]  rsp_removed_data;
   logic           rsp_error;
   logic [LW-1:0]  rsp_queue_level;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [LW-1:0]  csr_per_queue_limit = '0;

   // Model of the pool and the queues
   logic [LW-1:0] node_link [NODE_COUNT];
   logic [DW-1:0] node_data [NODE_COUNT];
   logic [LW-1:0] free_top;
   logic [LW-1:0] q_head  [QUEUE_COUNT];
   logic [LW-1:0] q_tail  [QUEUE_COUNT];
   logic [LW-1:0] q_count [QUEUE_COUNT];
   logic [LW-1:0] limit_reg;

   request_type request_backlog [$];
   outcome_type outcome_fifo [$];
   int       queued_total = 0;
   int       accepted_total = 0;
   int       fail_count = 0;
   int       cycle_count = 0;
   bit       req_fire = 1'b0;
   bit       send_idle = 1'b1;
   bit       recv_idle = 1'b1;
   bit       hold_arm = 1'b0;
   int       send_gap = 0;
   int       recv_gap = 0;
   int       hold_left = 0;

   shared_pool_linked_queues uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_queue_id        (req_queue_id),
      .req_item_data       (req_item_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_removed_data    (rsp_removed_data),
      .rsp_error           (rsp_error),
      .rsp_queue_level     (rsp_queue_level),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_per_queue_limit (csr_per_queue_limit)
   );

   always #6 clock = ~clock;

   // Applies one request to the model and returns the result it should give.
   function automatic outcome_type apply_request(request_type r);
      outcome_type     o;
      logic [LW-1:0]   slot;
      logic [LW-1:0]   tail;
      o = '0;
      o.err = 1'b1;
      if (r.kind == splq_pkg::REQ_INSERT) begin
         if (free_top < NULL_LINK && q_count[r.qid] < limit_reg) begin
            slot = free_top;
            free_top = node_link[slot[NODE_AW-1:0]];
            node_data[slot[NODE_AW-1:0]] = r.data;
            node_link[slot[NODE_AW-1:0]] = NULL_LINK;
            tail = q_tail[r.qid];
            if (q_count[r.qid] != 0 && tail < NULL_LINK) begin
               node_link[tail[NODE_AW-1:0]] = slot;
            end else begin
               q_head[r.qid] = slot;
            end
            q_tail[r.qid] = slot;
            q_count[r.qid] = q_count[r.qid] + LW'(1);
            o.err = 1'b0;
         end
      end else begin
         if (q_count[r.qid] != 0 && q_head[r.qid] < NULL_LINK) begin
            slot = q_head[r.qid];
            o.removed = node_data[slot[NODE_AW-1:0]];
            q_head[r.qid] = node_link[slot[NODE_AW-1:0]];
            q_count[r.qid] = q_count[r.qid] - LW'(1);
            if (q_head[r.qid] >= NULL_LINK || q_count[r.qid] == 0) begin
               q_head[r.qid] = NULL_LINK;
               q_tail[r.qid] = NULL_LINK;
            end
            node_link[slot[NODE_AW-1:0]] = free_top;
            free_top = slot;
            o.err = 1'b0;
         end
      end
      o.level = q_count[r.qid];
      return o;
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic add_request(logic kind, int qid, logic [DW-1:0] data);
      request_type r;
      r.kind = kind;
      r.qid = QW'(qid);
      r.data = data;
      request_backlog.push_back(r);
      queued_total++;
   endtask

   task automatic add_random_requests(int count, int insert_pct, int focus);
      int qid;
      for (int k = 0; k < count; k++) begin
         if (focus >= 0 && $urandom_range(0, 3) != 0) begin
            qid = focus;
         end else begin
            qid = $urandom_range(0, QUEUE_COUNT - 1);
         end
         add_request(($urandom_range(0, 99) < insert_pct) ?
                     splq_pkg::REQ_INSERT : splq_pkg::REQ_REMOVE,
                     qid, $urandom);
      end
   endtask

   // Returns on a falling edge once every beat has been taken and answered.
   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (accepted_total != queued_total || outcome_fifo.size() != 0);
   endtask

   task automatic write_limit(logic [LW-1:0] value);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_per_queue_limit <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      limit_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender: a payload stays put until its beat is taken.
   always @(negedge clock) begin : driver
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (send_idle && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         send_gap = $urandom_range(1, 14) - 1;
      end else if (request_backlog.size() != 0) begin
         next_req = request_backlog.pop_front();
         req_valid <= 1'b1;
         req_type <= next_req.kind;
         req_queue_id <= next_req.qid;
         req_item_data <= next_req.data;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off when armed.
   always @(negedge clock) begin : receiver
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_arm) begin
         hold_arm = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         rsp_stall <= 1'b1;
         recv_gap--;
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         recv_gap = $urandom_range(1, 14) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      request_type r;
      outcome_type got;
      outcome_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         req_fire = !reset && req_valid && !req_stall;
         if (req_fire) begin
            r.kind = req_type;
            r.qid = req_queue_id;
            r.data = req_item_data;
            outcome_fifo.push_back(apply_request(r));
            accepted_total++;
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            got.removed = rsp_removed_data;
            got.err = rsp_error;
            got.level = rsp_queue_level;
            if (outcome_fifo.size() == 0) begin
               note_failure($sformatf("unexpected result beat: data %h error %b level %0d",
                                      got.removed, got.err, got.level));
            end else begin
               want = outcome_fifo.pop_front();
               if (got.removed !== want.removed || got.err !== want.err ||
                   got.level !== want.level) begin
                  note_failure($sformatf(
                     "mismatch: expected data %h error %b level %0d, got data %h error %b level %0d",
                     want.removed, want.err, want.level, got.removed, got.err, got.level));
               end
            end
         end
      end
   end

   initial begin
      logic [LW-1:0] lim;
      int            pct;
      int            focus;
      int            count;
      for (int i = 0; i < NODE_COUNT; i++) begin
         node_link[i] = LW'(i + 1);
         node_data[i] = '0;
      end
      free_top = '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
         q_head[i] = NULL_LINK;
         q_tail[i] = NULL_LINK;
         q_count[i] = '0;
      end
      limit_reg = splq_pkg::LIMIT_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats at the reset limit: empty removes, extreme payloads,
      // one queue run dry.
      @(posedge clock);
      for (int i = 0; i < QUEUE_COUNT; i++) begin
         add_request(splq_pkg::REQ_REMOVE, i, '1);
      end
      add_request(splq_pkg::REQ_INSERT, 0, 32'h0000_0000);
      add_request(splq_pkg::REQ_INSERT, 0, 32'hFFFF_FFFF);
      add_request(splq_pkg::REQ_INSERT, 1, 32'hA5A5_A5A5);
      add_request(splq_pkg::REQ_INSERT, 2, 32'h5A5A_5A5A);
      add_request(splq_pkg::REQ_INSERT, 3, 32'h1234_5678);
      add_request(splq_pkg::REQ_REMOVE, 0, 32'h0);
      add_request(splq_pkg::REQ_REMOVE, 0, 32'h0);
      add_request(splq_pkg::REQ_REMOVE, 0, 32'h0);
      add_request(splq_pkg::REQ_REMOVE, 1, 32'h0);
      add_request(splq_pkg::REQ_REMOVE, 2, 32'h0);
      add_request(splq_pkg::REQ_REMOVE, 3, 32'h0);
      wait_for_drain();

      // Queue at its limit, then a limit of zero that refuses every insert.
      write_limit(7'd1);
      @(posedge clock);
      add_request(splq_pkg::REQ_INSERT, 0, 32'hDEAD_BEEF);
      add_request(splq_pkg::REQ_INSERT, 0, 32'hCAFE_F00D);
      add_request(splq_pkg::REQ_REMOVE, 0, 32'h0);
      wait_for_drain();
      write_limit(7'd0);
      @(posedge clock);
      add_request(splq_pkg::REQ_INSERT, 1, 32'h8000_0001);
      add_request(splq_pkg::REQ_INSERT, 2, 32'h7FFF_FFFE);
      add_request(splq_pkg::REQ_REMOVE, 1, 32'h0);
      wait_for_drain();

      for (int k = 0; k < 14; k++) begin
         count = 150;
         focus = -1;
         case (k)
            0: begin lim = 7'd30;  pct = 60; end
            1: begin lim = 7'd64;  pct = 85; focus = 0; end
            2: begin lim = 7'd127; pct = 90; end
            3: begin lim = 7'd1;   pct = 50; end
            4: begin lim = 7'd2;   pct = 50; end
            5: begin lim = 7'd64;  pct = 20; end
            6: begin lim = LW'($urandom_range(1, 64)); pct = 55; focus = 2; end
            7: begin lim = 7'd127; pct = 90; focus = 3; end
            8: begin lim = 7'd0;   pct = 80; count = 24; end
            9: begin lim = LW'($urandom_range(1, 64)); pct = 50; end
            10: begin lim = 7'd16; pct = 75; focus = 1; end
            11: begin lim = 7'd64; pct = 40; end
            12: begin lim = 7'd30; pct = 50; end
            default: begin lim = 7'd127; pct = 50; end
         endcase
         write_limit(lim);
         @(posedge clock);
         // Phase 4 and the closing phases run with both sides at full rate.
         send_idle = !(k == 4 || k >= 12);
         recv_idle = !(k == 4 || k >= 12);
         add_random_requests(count, pct, focus);
         // A long receiver hold-off while the pool is being filled.
         if (k == 2) begin
            hold_arm = 1'b1;
         end
         wait_for_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outcome_fifo.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
